// ----- rtl/core/serial_boot_image_loader_macros.svh -----
// Assertion macros for the serial boot image loader.
// Both macros sample on the rising edge of clk and are disabled in reset.
`ifndef SERIAL_BOOT_IMAGE_LOADER_MACROS_SVH
`define SERIAL_BOOT_IMAGE_LOADER_MACROS_SVH

`ifndef SYNTHESIS

// Check cons in the same cycle as ante
`define SBIL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define SBIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SBIL_ASSERT_SAME(lbl, ante, cons, msg)
`define SBIL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/sbil_pkg.sv -----
`default_nettype none

package sbil_pkg;

  // Address width of the write pointer
  localparam int ADDR_W = 32;

  // Register file
  localparam int         CFG_AW       = 3;
  localparam logic       REG_KERNEL   = 1'b0;
  localparam logic       REG_INFO     = 1'b1;
  localparam logic [31:0] KERNEL_RST  = 32'h0010_0000;
  localparam logic [31:0] INFO_RST    = 32'h000f_e000;

  // Result kinds
  localparam logic [1:0] KIND_TX    = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_BOOT  = 2'd2;

  // Input functions
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // Transmit bytes
  localparam logic [7:0] TX_BREAK = 8'h03;
  localparam logic [7:0] TX_ACK   = 8'h06;

  // Protocol phases
  localparam logic [2:0] PH_SIZE1 = 3'd0;
  localparam logic [2:0] PH_DATA1 = 3'd1;
  localparam logic [2:0] PH_SIZE2 = 3'd2;
  localparam logic [2:0] PH_DATA2 = 3'd3;
  localparam logic [2:0] PH_ENTRY = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [31:0] mem_addr;
    logic [7:0]  mem_data;
    logic [31:0] entry_addr;
    logic        last;
  } out_item_t;

  // Build one result with last cleared
  function automatic out_item_t mk_res(input logic [1:0] kind, input logic [7:0] tx,
                                       input logic [31:0] addr, input logic [7:0] data,
                                       input logic [31:0] entry);
    out_item_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.mem_addr   = addr;
    r.mem_data   = data;
    r.entry_addr = entry;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/serial_boot_image_loader.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | sbil_pkg::in_item_t (func, rx_byte)
// out     | output    | out_valid / out_ready| sbil_pkg::out_item_t (one result)
// cfg     | input     | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// A request is decoded when accepted and leaves zero to three results in a
// three-entry buffer that feeds the output register one result a cycle unless
// out stalls; the next request is taken as the last result leaves the buffer,
// at once if none was left. rst_n is synchronous: it clears protocol state,
// buffer count and out_valid, and restores the bases. A stall on out holds
// in_ready low until the last buffered result moves into the output register.
`default_nettype none

`include "serial_boot_image_loader_macros.svh"

module serial_boot_image_loader (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  sbil_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output sbil_pkg::out_item_t         out_data,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [sbil_pkg::CFG_AW-1:0]  paddr,
  input  wire [31:0]                  pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sbil_pkg::*;

  // Base registers
  logic [31:0] kernel_base_r;
  logic [31:0] info_base_r;

  // Protocol state
  logic [2:0]        phase_r, phase_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [31:0]       left_r, left_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;

  // Result buffer and output register
  out_item_t   buf_r [3];
  out_item_t   buf_nxt [3];
  logic [1:0]  cnt_r, cnt_nxt;
  out_item_t   res [3];
  logic [1:0]  res_n;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        accept;
  logic        move;
  logic        cfg_wr;
  logic [31:0] word_or;
  logic [31:0] size_base;
  logic        start_acc;
  logic        data_acc;

  assign accept = in_valid && in_ready;
  assign move   = (cnt_r != 2'd0) && (!out_valid_r || out_ready);
  assign cfg_wr = psel && penable && pwrite;

  // Take a new request once the buffer is empty or its last result is leaving
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && move);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_INFO) ? info_base_r : kernel_base_r;

  assign start_acc = accept && (in_data.func == FUNC_START);
  assign data_acc  = accept && (in_data.func == FUNC_BYTE) &&
                     (phase_r == PH_DATA1 || phase_r == PH_DATA2);

  // Merge the incoming byte into the little-endian word
  assign word_or   = word_r | (32'(in_data.rx_byte) << {slot_r, 3'b000});
  assign size_base = (phase_r == PH_SIZE1) ? kernel_base_r : info_base_r;

  // Decode one request into its results and the next protocol state
  always_comb begin
    phase_nxt = phase_r;
    slot_nxt  = slot_r;
    word_nxt  = word_r;
    left_nxt  = left_r;
    wp_nxt    = wp_r;
    res_n     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    if (in_data.func == FUNC_START) begin
      phase_nxt = PH_SIZE1;
      slot_nxt  = 2'd0;
      word_nxt  = '0;
      left_nxt  = '0;
      wp_nxt    = '0;
      for (int i = 0; i < 3; i++) begin
        res[i] = mk_res(KIND_TX, TX_BREAK, '0, '0, '0);
      end
      res[2].last = 1'b1;
      res_n = 2'd3;
    end else begin
      case (phase_r)
        PH_SIZE1, PH_SIZE2: begin
          word_nxt = word_or;
          slot_nxt = slot_r + 2'd1;
          if (slot_r == 2'd3) begin
            left_nxt = word_or;
            word_nxt = '0;
            wp_nxt   = ADDR_W'(size_base);
            res[0]   = mk_res(KIND_TX, TX_ACK, '0, '0, '0);
            if (word_or == 32'd0) begin
              res[1]      = mk_res(KIND_TX, TX_ACK, '0, '0, '0);
              res[1].last = 1'b1;
              res_n       = 2'd2;
              phase_nxt   = (phase_r == PH_SIZE1) ? PH_SIZE2 : PH_ENTRY;
            end else begin
              res[0].last = 1'b1;
              res_n       = 2'd1;
              phase_nxt   = (phase_r == PH_SIZE1) ? PH_DATA1 : PH_DATA2;
            end
          end
        end
        PH_DATA1, PH_DATA2: begin
          res[0]   = mk_res(KIND_WRITE, '0, 32'(wp_r), in_data.rx_byte, '0);
          wp_nxt   = wp_r + ADDR_W'(1);
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            res[1]      = mk_res(KIND_TX, TX_ACK, '0, '0, '0);
            res[1].last = 1'b1;
            res_n       = 2'd2;
            phase_nxt   = (phase_r == PH_DATA1) ? PH_SIZE2 : PH_ENTRY;
          end else begin
            res[0].last = 1'b1;
            res_n       = 2'd1;
          end
        end
        PH_ENTRY: begin
          word_nxt = word_or;
          slot_nxt = slot_r + 2'd1;
          if (slot_r == 2'd3) begin
            res[0]      = mk_res(KIND_TX, TX_ACK, '0, '0, '0);
            res[1]      = mk_res(KIND_BOOT, '0, '0, '0, word_or);
            res[1].last = 1'b1;
            res_n       = 2'd2;
            phase_nxt   = PH_DONE;
          end
        end
        default: begin
          // drop bytes after boot
        end
      endcase
    end
  end

  // Fill the buffer on a request, shift it as results leave
  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < 3; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (accept) begin
      cnt_nxt = res_n;
      for (int i = 0; i < 3; i++) begin
        buf_nxt[i] = res[i];
      end
    end else if (move) begin
      cnt_nxt    = cnt_r - 2'd1;
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
    end
  end

  // Protocol state and base registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SIZE1;
      slot_r        <= 2'd0;
      word_r        <= '0;
      left_r        <= '0;
      wp_r          <= '0;
      kernel_base_r <= KERNEL_RST;
      info_base_r   <= INFO_RST;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        slot_r  <= slot_nxt;
        word_r  <= word_nxt;
        left_r  <= left_nxt;
        wp_r    <= wp_nxt;
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_INFO) begin
          info_base_r <= pwdata;
        end else begin
          kernel_base_r <= pwdata;
        end
      end
    end
  end

  // Buffer count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Buffer entries and output payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    if (move) begin
      out_data_r <= buf_r[0];
    end
  end

  // A start request leaves all three breaks queued
  `SBIL_ASSERT_NEXT(a_start_fill, start_acc, cnt_r == 2'd3, "start did not queue three results")
  // The newest queued result of a request carries last
  `SBIL_ASSERT_SAME(a_last_tail, cnt_r != 2'd0, buf_r[cnt_r - 2'd1].last, "queue tail lacks last")
  // Each image byte advances the write pointer by one
  `SBIL_ASSERT_NEXT(a_wp_step, data_acc, wp_r == $past(wp_r) + ADDR_W'(1), "wp did not step")

endmodule

`default_nettype wire
